@@ hw/rtl/digit_label_overlay_macros.svh @@
// Assertion helpers for the label overlay. Every check is sampled on clk and
// switched off while rst_n is low.
`ifndef DIGIT_LABEL_OVERLAY_MACROS_SVH
`define DIGIT_LABEL_OVERLAY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dlo_pkg.sv @@
package dlo_pkg;

    // Register map, one 32-bit word per register.
    typedef enum logic [2:0] {
        REG_CENTRE_ROW       = 3'd0,
        REG_CENTRE_COL       = 3'd1,
        REG_LABEL_VALUE      = 3'd2,
        REG_GLYPH_HEIGHT     = 3'd3,
        REG_GLYPH_WIDTH      = 3'd4,
        REG_STROKE_HALF_ROWS = 3'd5,
        REG_STROKE_HALF_COLS = 3'd6
    } reg_idx_t;

    localparam int VALUE_BITS  = 7;
    localparam int SIZE_BITS   = 10;
    localparam int HALF_BITS   = 7;
    localparam int DIGIT_BITS  = 4;

    localparam logic [SIZE_BITS-1:0] GLYPH_HEIGHT_RST = 10'd48;
    localparam logic [SIZE_BITS-1:0] GLYPH_WIDTH_RST  = 10'd32;
    localparam logic [HALF_BITS-1:0] HALF_ROWS_RST    = 7'd2;
    localparam logic [HALF_BITS-1:0] HALF_COLS_RST    = 7'd1;

    localparam logic [VALUE_BITS-1:0] VALUE_ONE_DIGIT = 7'd10;
    localparam logic [VALUE_BITS-1:0] VALUE_LIMIT     = 7'd100;

    // Stroke set of one glyph, one bit per stroke.
    typedef logic [8:0] stroke_set_t;

    localparam int S_TOP   = 0;
    localparam int S_BOT   = 1;
    localparam int S_MID   = 2;
    localparam int S_LEFT  = 3;
    localparam int S_RIGHT = 4;
    localparam int S_LUP   = 5;
    localparam int S_RUP   = 6;
    localparam int S_LLOW  = 7;
    localparam int S_RLOW  = 8;

    typedef struct packed {
        logic [SIZE_BITS-1:0] height;
        logic [SIZE_BITS-1:0] width;
        logic [HALF_BITS-1:0] half_rows;
        logic [HALF_BITS-1:0] half_cols;
    } glyph_cfg_t;

    function automatic stroke_set_t digit_strokes(input logic [DIGIT_BITS-1:0] digit);
        stroke_set_t s;
        s = '0;
        unique case (digit)
            4'd0:
            begin
                s[S_TOP] = 1'b1; s[S_BOT] = 1'b1; s[S_LEFT] = 1'b1; s[S_RIGHT] = 1'b1;
            end
            4'd1:
            begin
                s[S_RIGHT] = 1'b1;
            end
            4'd2:
            begin
                s[S_TOP] = 1'b1; s[S_BOT] = 1'b1; s[S_MID] = 1'b1;
                s[S_RUP] = 1'b1; s[S_LLOW] = 1'b1;
            end
            4'd3:
            begin
                s[S_TOP] = 1'b1; s[S_BOT] = 1'b1; s[S_MID] = 1'b1; s[S_RIGHT] = 1'b1;
            end
            4'd4:
            begin
                s[S_MID] = 1'b1; s[S_RIGHT] = 1'b1; s[S_LUP] = 1'b1;
            end
            4'd5:
            begin
                s[S_TOP] = 1'b1; s[S_BOT] = 1'b1; s[S_MID] = 1'b1;
                s[S_LUP] = 1'b1; s[S_RLOW] = 1'b1;
            end
            4'd6:
            begin
                s[S_TOP] = 1'b1; s[S_BOT] = 1'b1; s[S_MID] = 1'b1;
                s[S_LEFT] = 1'b1; s[S_RLOW] = 1'b1;
            end
            4'd7:
            begin
                s[S_RIGHT] = 1'b1; s[S_TOP] = 1'b1; s[S_RLOW] = 1'b1; s[S_LUP] = 1'b1;
            end
            4'd8:
            begin
                s[S_TOP] = 1'b1; s[S_BOT] = 1'b1; s[S_LEFT] = 1'b1;
                s[S_RIGHT] = 1'b1; s[S_MID] = 1'b1;
            end
            4'd9:
            begin
                s[S_RIGHT] = 1'b1; s[S_TOP] = 1'b1; s[S_BOT] = 1'b1;
                s[S_MID] = 1'b1; s[S_LUP] = 1'b1;
            end
            default:
            begin
                s = '0;
            end
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/dlo_regs.sv @@
module dlo_regs #(
    parameter int COORD_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [4:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [COORD_BITS-1:0]              centre_row,
    output logic [COORD_BITS-1:0]              centre_col,
    output logic [dlo_pkg::VALUE_BITS-1:0]     label_value,
    output dlo_pkg::glyph_cfg_t                glyph_cfg
);

    logic [COORD_BITS-1:0]          centre_row_reg;
    logic [COORD_BITS-1:0]          centre_col_reg;
    logic [dlo_pkg::VALUE_BITS-1:0] label_value_reg;
    dlo_pkg::glyph_cfg_t            glyph_cfg_reg;
    dlo_pkg::reg_idx_t              idx;
    logic                           wr_en;

    assign pready = 1'b1;
    assign idx    = dlo_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_row_reg          <= '0;
            centre_col_reg          <= '0;
            label_value_reg         <= '0;
            glyph_cfg_reg.height    <= dlo_pkg::GLYPH_HEIGHT_RST;
            glyph_cfg_reg.width     <= dlo_pkg::GLYPH_WIDTH_RST;
            glyph_cfg_reg.half_rows <= dlo_pkg::HALF_ROWS_RST;
            glyph_cfg_reg.half_cols <= dlo_pkg::HALF_COLS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                dlo_pkg::REG_CENTRE_ROW:
                    centre_row_reg <= pwdata[COORD_BITS-1:0];
                dlo_pkg::REG_CENTRE_COL:
                    centre_col_reg <= pwdata[COORD_BITS-1:0];
                dlo_pkg::REG_LABEL_VALUE:
                    label_value_reg <= pwdata[dlo_pkg::VALUE_BITS-1:0];
                dlo_pkg::REG_GLYPH_HEIGHT:
                    glyph_cfg_reg.height <= pwdata[dlo_pkg::SIZE_BITS-1:0];
                dlo_pkg::REG_GLYPH_WIDTH:
                    glyph_cfg_reg.width <= pwdata[dlo_pkg::SIZE_BITS-1:0];
                dlo_pkg::REG_STROKE_HALF_ROWS:
                    glyph_cfg_reg.half_rows <= pwdata[dlo_pkg::HALF_BITS-1:0];
                dlo_pkg::REG_STROKE_HALF_COLS:
                    glyph_cfg_reg.half_cols <= pwdata[dlo_pkg::HALF_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            dlo_pkg::REG_CENTRE_ROW:       prdata = 32'(centre_row_reg);
            dlo_pkg::REG_CENTRE_COL:       prdata = 32'(centre_col_reg);
            dlo_pkg::REG_LABEL_VALUE:      prdata = 32'(label_value_reg);
            dlo_pkg::REG_GLYPH_HEIGHT:     prdata = 32'(glyph_cfg_reg.height);
            dlo_pkg::REG_GLYPH_WIDTH:      prdata = 32'(glyph_cfg_reg.width);
            dlo_pkg::REG_STROKE_HALF_ROWS: prdata = 32'(glyph_cfg_reg.half_rows);
            dlo_pkg::REG_STROKE_HALF_COLS: prdata = 32'(glyph_cfg_reg.half_cols);
            default:                       prdata = '0;
        endcase
    end

    assign centre_row  = centre_row_reg;
    assign centre_col  = centre_col_reg;
    assign label_value = label_value_reg;
    assign glyph_cfg   = glyph_cfg_reg;

endmodule

@@ hw/rtl/dlo_glyph.sv @@
// Decides whether glyph cell (m, n) of one digit is dark. Every stroke is a
// rectangle grown by the half thicknesses, so each test compares m and n against its bounds.
module dlo_glyph #(
    parameter int SW = 14
) (
    input  logic [dlo_pkg::DIGIT_BITS-1:0] digit,
    input  logic signed [SW-1:0]           m,
    input  logic signed [SW-1:0]           n,
    input  dlo_pkg::glyph_cfg_t            cfg,
    output logic                           dark
);

    logic signed [SW-1:0] hs;
    logic signed [SW-1:0] ws;
    logic signed [SW-1:0] mid;
    logic signed [SW-1:0] hrs;
    logic signed [SW-1:0] hcs;
    dlo_pkg::stroke_set_t strokes;
    logic in_glyph;
    logic row_top, row_bot, row_mid, row_up, row_low;
    logic col_left, col_right;

    assign hs  = $signed({{(SW-dlo_pkg::SIZE_BITS){1'b0}}, cfg.height});
    assign ws  = $signed({{(SW-dlo_pkg::SIZE_BITS){1'b0}}, cfg.width});
    assign mid = $signed({{(SW-dlo_pkg::SIZE_BITS+1){1'b0}},
                          cfg.height[dlo_pkg::SIZE_BITS-1:1]});
    assign hrs = $signed({{(SW-dlo_pkg::HALF_BITS){1'b0}}, cfg.half_rows});
    assign hcs = $signed({{(SW-dlo_pkg::HALF_BITS){1'b0}}, cfg.half_cols});

    assign strokes = dlo_pkg::digit_strokes(digit);

    // Row 0 and column 0 of a glyph stay light.
    assign in_glyph = (m >= SW'(1)) && (n >= SW'(1)) && (m < hs) && (n < ws);

    assign row_top   = m <= hrs;
    assign row_bot   = m >= hs - SW'(1) - hrs;
    assign row_mid   = (m >= mid - hrs) && (m <= mid + hrs);
    // Half-height side strokes vanish when the glyph is too short to hold them.
    assign row_up    = (mid >= SW'(2)) && (m <= mid - SW'(1) + hrs);
    assign row_low   = (hs >= SW'(3)) && (m >= mid + SW'(1) - hrs);
    assign col_left  = n <= hcs;
    assign col_right = n >= ws - SW'(1) - hcs;

    assign dark = in_glyph && (
        (strokes[dlo_pkg::S_TOP]   && row_top)  ||
        (strokes[dlo_pkg::S_BOT]   && row_bot)  ||
        (strokes[dlo_pkg::S_MID]   && row_mid)  ||
        (strokes[dlo_pkg::S_LEFT]  && col_left) ||
        (strokes[dlo_pkg::S_RIGHT] && col_right) ||
        (strokes[dlo_pkg::S_LUP]   && row_up  && col_left)  ||
        (strokes[dlo_pkg::S_RUP]   && row_up  && col_right) ||
        (strokes[dlo_pkg::S_LLOW]  && row_low && col_left)  ||
        (strokes[dlo_pkg::S_RLOW]  && row_low && col_right));

endmodule

@@ hw/rtl/digit_label_overlay.sv @@
// Channel  | Direction | Signals                         | Carries
// s_*      | in        | s_tvalid, s_tready, s_tdata     | pixel row, column and grey level
// m_*      | out       | m_tvalid, m_tready, m_tdata     | grey level after the overlay
// APB      | in/out    | psel, penable, pwrite, paddr... | seven control registers
//
// One word per clock sustained while m_tready is high. Each word passes the
// input register, then the glyph compares feed the output register.
// m_tvalid rises when the word moves from the input to the output register.
// rst_n clears both stage valid flags and loads the register reset values.
// A stall on m_tready holds the output word; the input stage keeps
// accepting until it too is full, so no bubble is added when the stall ends.
module digit_label_overlay #(
    parameter int COORD_BITS = 12,
    localparam int S_TDATA_W = ((2 * COORD_BITS + 8 + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pixel_row, pixel_col, pixel_in (from the lowest bit up), then zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_out
    output logic [7:0]           m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    `include "digit_label_overlay_macros.svh"

    localparam int SW = ((COORD_BITS > dlo_pkg::SIZE_BITS) ? COORD_BITS
                                                           : dlo_pkg::SIZE_BITS) + 2;

    logic [COORD_BITS-1:0]          centre_row;
    logic [COORD_BITS-1:0]          centre_col;
    logic [dlo_pkg::VALUE_BITS-1:0] label_value;
    dlo_pkg::glyph_cfg_t            glyph_cfg;

    dlo_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .centre_row  (centre_row),
        .centre_col  (centre_col),
        .label_value (label_value),
        .glyph_cfg   (glyph_cfg)
    );

    // Pipeline control
    logic                  s1_valid_reg, s1_valid_next;
    logic [COORD_BITS-1:0] s1_row_reg, s1_row_next;
    logic [COORD_BITS-1:0] s1_col_reg, s1_col_next;
    logic [7:0]            s1_pix_reg, s1_pix_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_pix_reg, out_pix_next;
    logic                  s1_adv;
    logic                  s_take;
    logic                  dark;

    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_row_next    = s1_row_reg;
        s1_col_next    = s1_col_reg;
        s1_pix_next    = s1_pix_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        if (s_tready)
        begin
            s1_valid_next = s_tvalid;
            s1_row_next   = s_tdata[COORD_BITS-1:0];
            s1_col_next   = s_tdata[2*COORD_BITS-1:COORD_BITS];
            s1_pix_next   = s_tdata[2*COORD_BITS+7:2*COORD_BITS];
        end
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
            out_pix_next   = dark ? 8'd0 : s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg  <= s1_row_next;
        s1_col_reg  <= s1_col_next;
        s1_pix_reg  <= s1_pix_next;
        out_pix_reg <= out_pix_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;

    // Glyph placement
    logic signed [SW-1:0] row_s, col_s, crow_s, ccol_s;
    logic signed [SW-1:0] h_s, w_s, h_half_s, w_half_s, h_even_s, w_even_s;
    logic signed [SW-1:0] m, n_single, n_tens, n_units;
    logic signed [SW-1:0] n_a;
    logic [14:0]          tens_prod;
    logic [dlo_pkg::DIGIT_BITS-1:0] tens, units, digit_a;
    logic [6:0]           tens_x10;
    logic [6:0]           units_full;
    logic                 single, base_ok, m_ok, na_ok, nb_ok;
    logic                 dark_a, dark_b;

    assign row_s    = $signed({{(SW-COORD_BITS){1'b0}}, s1_row_reg});
    assign col_s    = $signed({{(SW-COORD_BITS){1'b0}}, s1_col_reg});
    assign crow_s   = $signed({{(SW-COORD_BITS){1'b0}}, centre_row});
    assign ccol_s   = $signed({{(SW-COORD_BITS){1'b0}}, centre_col});
    assign h_s      = $signed({{(SW-dlo_pkg::SIZE_BITS){1'b0}}, glyph_cfg.height});
    assign w_s      = $signed({{(SW-dlo_pkg::SIZE_BITS){1'b0}}, glyph_cfg.width});
    assign h_half_s = $signed({{(SW-dlo_pkg::SIZE_BITS+1){1'b0}},
                               glyph_cfg.height[dlo_pkg::SIZE_BITS-1:1]});
    assign w_half_s = $signed({{(SW-dlo_pkg::SIZE_BITS+1){1'b0}},
                               glyph_cfg.width[dlo_pkg::SIZE_BITS-1:1]});
    assign h_even_s = $signed({{(SW-dlo_pkg::SIZE_BITS){1'b0}},
                               glyph_cfg.height[dlo_pkg::SIZE_BITS-1:1], 1'b0});
    assign w_even_s = $signed({{(SW-dlo_pkg::SIZE_BITS){1'b0}},
                               glyph_cfg.width[dlo_pkg::SIZE_BITS-1:1], 1'b0});

    assign m        = row_s - crow_s + h_half_s - SW'(1);
    assign n_single = col_s - ccol_s + w_half_s;
    assign n_tens   = col_s - ccol_s + w_s;
    assign n_units  = col_s - ccol_s;

    // Tens digit by multiplying with 205/2048, exact for values below 100.
    assign tens_prod  = {8'd0, label_value} * 15'd205;
    assign tens       = tens_prod[14:11];
    assign tens_x10   = {3'd0, tens} * 7'd10;
    assign units_full = label_value - tens_x10;
    assign units      = units_full[dlo_pkg::DIGIT_BITS-1:0];

    assign single  = label_value < dlo_pkg::VALUE_ONE_DIGIT;
    assign m_ok    = (m >= SW'(0)) && (m <= h_even_s - SW'(2));
    assign base_ok = (s1_row_reg != '0) && (s1_col_reg != '0) &&
                     (label_value < dlo_pkg::VALUE_LIMIT) && m_ok;

    assign digit_a = single ? label_value[dlo_pkg::DIGIT_BITS-1:0] : tens;
    assign n_a     = single ? n_single : n_tens;
    assign na_ok   = single ? ((n_single >= SW'(1)) && (n_single <= w_even_s - SW'(1)))
                            : ((n_tens >= SW'(1)) && (n_tens <= w_s - SW'(1)));
    assign nb_ok   = !single && (n_units >= SW'(1)) && (n_units <= w_s);

    dlo_glyph #(
        .SW (SW)
    ) u_glyph_a (
        .digit (digit_a),
        .m     (m),
        .n     (n_a),
        .cfg   (glyph_cfg),
        .dark  (dark_a)
    );

    dlo_glyph #(
        .SW (SW)
    ) u_glyph_b (
        .digit (units),
        .m     (m),
        .n     (n_units),
        .cfg   (glyph_cfg),
        .dark  (dark_b)
    );

    assign dark = base_ok && ((na_ok && dark_a) || (nb_ok && dark_b));

    // Checks
    `DLO_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !s1_adv, s1_valid_reg,
        "input stage dropped a word while the output was stalled")
    `DLO_ASSERT_NEXT(a_pass_or_black, s1_valid_reg && s1_adv,
        (out_pix_reg == $past(s1_pix_reg)) || (out_pix_reg == 8'd0),
        "output pixel is neither the input pixel nor black")
    `DLO_ASSERT_NEXT(a_large_value,
        s1_valid_reg && s1_adv && (label_value >= dlo_pkg::VALUE_LIMIT),
        out_pix_reg == $past(s1_pix_reg),
        "pixel changed although the label value draws nothing")
    `DLO_ASSERT_NEXT(a_image_origin,
        s1_valid_reg && s1_adv && ((s1_row_reg == '0) || (s1_col_reg == '0)),
        out_pix_reg == $past(s1_pix_reg),
        "pixel in image row 0 or column 0 was overwritten")
    `DLO_ASSERT_NEXT(a_take_fills, s_take, s1_valid_reg,
        "accepted word did not reach the input stage")

endmodule

@@ sim/label_overlay_checker.sv @@
`timescale 1ns / 100ps
module label_overlay_checker
    import dlo_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int TDATA_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [7:0]         m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 mismatches,
    output int                 words_due
);

    typedef struct {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic [7:0]            grey;
    } overlay_word_t;

    localparam stroke_set_t SS_TOP   = stroke_set_t'(1 << S_TOP);
    localparam stroke_set_t SS_BOT   = stroke_set_t'(1 << S_BOT);
    localparam stroke_set_t SS_MID   = stroke_set_t'(1 << S_MID);
    localparam stroke_set_t SS_LEFT  = stroke_set_t'(1 << S_LEFT);
    localparam stroke_set_t SS_RIGHT = stroke_set_t'(1 << S_RIGHT);
    localparam stroke_set_t SS_LUP   = stroke_set_t'(1 << S_LUP);
    localparam stroke_set_t SS_RUP   = stroke_set_t'(1 << S_RUP);
    localparam stroke_set_t SS_LLOW  = stroke_set_t'(1 << S_LLOW);
    localparam stroke_set_t SS_RLOW  = stroke_set_t'(1 << S_RLOW);

    // Indexed by digit; digit 9 stands first in the concatenation.
    localparam logic [9:0][8:0] DIGIT_GLYPH = {
        SS_RIGHT | SS_TOP | SS_BOT | SS_MID | SS_LUP,
        SS_TOP | SS_BOT | SS_LEFT | SS_RIGHT | SS_MID,
        SS_RIGHT | SS_TOP | SS_RLOW | SS_LUP,
        SS_TOP | SS_BOT | SS_MID | SS_LEFT | SS_RLOW,
        SS_TOP | SS_BOT | SS_MID | SS_LUP | SS_RLOW,
        SS_MID | SS_RIGHT | SS_LUP,
        SS_TOP | SS_BOT | SS_MID | SS_RIGHT,
        SS_TOP | SS_BOT | SS_MID | SS_RUP | SS_LLOW,
        SS_RIGHT,
        SS_TOP | SS_BOT | SS_LEFT | SS_RIGHT
    };

    logic [COORD_BITS-1:0] ctr_row;
    logic [COORD_BITS-1:0] ctr_col;
    logic [VALUE_BITS-1:0] label;
    logic [SIZE_BITS-1:0]  glyph_h;
    logic [SIZE_BITS-1:0]  glyph_w;
    logic [HALF_BITS-1:0]  half_r;
    logic [HALF_BITS-1:0]  half_c;
    overlay_word_t         grey_due[$];
    int                    errors = 0;

    function automatic bit stroke_hit(int m, int n, int r0, int r1, int c0, int c1);
        int hr;
        int hc;
        hr = int'(half_r);
        hc = int'(half_c);
        if (r0 > r1 || c0 > c1)
            return 1'b0;
        return m >= r0 - hr && m <= r1 + hr && n >= c0 - hc && n <= c1 + hc;
    endfunction

    function automatic bit glyph_cell_dark(int digit, int m, int n);
        int          h;
        int          w;
        int          mid;
        stroke_set_t s;
        h = int'(glyph_h);
        w = int'(glyph_w);
        mid = h / 2;
        if (digit > 9 || m <= 0 || n <= 0 || m >= h || n >= w)
            return 1'b0;
        s = DIGIT_GLYPH[digit];
        return (s[S_TOP]   && stroke_hit(m, n, 0, 0, 0, w - 1))
            || (s[S_BOT]   && stroke_hit(m, n, h - 1, h - 1, 0, w - 1))
            || (s[S_MID]   && stroke_hit(m, n, mid, mid, 0, w - 1))
            || (s[S_LEFT]  && stroke_hit(m, n, 0, h - 1, 0, 0))
            || (s[S_RIGHT] && stroke_hit(m, n, 0, h - 1, w - 1, w - 1))
            || (s[S_LUP]   && stroke_hit(m, n, 1, mid - 1, 0, 0))
            || (s[S_RUP]   && stroke_hit(m, n, 1, mid - 1, w - 1, w - 1))
            || (s[S_LLOW]  && stroke_hit(m, n, mid + 1, h - 1, 0, 0))
            || (s[S_RLOW]  && stroke_hit(m, n, mid + 1, h - 1, w - 1, w - 1));
    endfunction

    function automatic logic [7:0] overlay_grey(logic [COORD_BITS-1:0] row,
                                                logic [COORD_BITS-1:0] col,
                                                logic [7:0] grey);
        int h;
        int w;
        int m;
        int n;
        bit dark;
        h = int'(glyph_h);
        w = int'(glyph_w);
        m = int'(row) - int'(ctr_row) + h / 2 - 1;
        dark = 1'b0;
        if (row != '0 && col != '0 && label < VALUE_LIMIT && m >= 0 && m <= 2 * (h / 2) - 2)
        begin
            if (label < VALUE_ONE_DIGIT)
            begin
                n = int'(col) - int'(ctr_col) + w / 2;
                if (n >= 1 && n <= 2 * (w / 2) - 1)
                    dark = glyph_cell_dark(int'(label), m, n);
            end
            else
            begin
                // Tens digit sits left of the centre column, units digit right of it.
                n = int'(col) - int'(ctr_col) + w;
                if (n >= 1 && n <= w - 1)
                    dark = glyph_cell_dark(int'(label) / 10, m, n);
                n = int'(col) - int'(ctr_col);
                if (n >= 1 && n <= w)
                    dark = dark || glyph_cell_dark(int'(label) % 10, m, n);
            end
        end
        return dark ? 8'd0 : grey;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        overlay_word_t due;
        if (!rst_n)
        begin
            ctr_row = '0;
            ctr_col = '0;
            label = '0;
            glyph_h = GLYPH_HEIGHT_RST;
            glyph_w = GLYPH_WIDTH_RST;
            half_r = HALF_ROWS_RST;
            half_c = HALF_COLS_RST;
            grey_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (grey_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: pixel_out %0d arrived with no word expected",
                             $time, m_tdata);
                end
                else
                begin
                    due = grey_due.pop_front();
                    if (m_tdata !== due.grey)
                    begin
                        errors++;
                        $display("%0t: pixel_out at row %0d col %0d: expected %0d, actual %0d",
                                 $time, due.row, due.col, due.grey, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                due.row = s_tdata[COORD_BITS-1:0];
                due.col = s_tdata[2*COORD_BITS-1:COORD_BITS];
                due.grey = overlay_grey(due.row, due.col, s_tdata[2*COORD_BITS +: 8]);
                grey_due.push_back(due);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_CENTRE_ROW:       ctr_row = pwdata[COORD_BITS-1:0];
                    REG_CENTRE_COL:       ctr_col = pwdata[COORD_BITS-1:0];
                    REG_LABEL_VALUE:      label = pwdata[VALUE_BITS-1:0];
                    REG_GLYPH_HEIGHT:     glyph_h = pwdata[SIZE_BITS-1:0];
                    REG_GLYPH_WIDTH:      glyph_w = pwdata[SIZE_BITS-1:0];
                    REG_STROKE_HALF_ROWS: half_r = pwdata[HALF_BITS-1:0];
                    REG_STROKE_HALF_COLS: half_c = pwdata[HALF_BITS-1:0];
                    default:              ;
                endcase
            end
        end
        mismatches <= errors;
        words_due <= grey_due.size();
    end

endmodule

@@ sim/tb_digit_label_overlay.sv @@
`timescale 1ns / 100ps
module tb_digit_label_overlay;
    import dlo_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int TDATA_W = ((2 * COORD_BITS + 8 + 7) / 8) * 8;
    localparam int PHASES = 24;
    localparam int PHASE_WORDS = 60;
    localparam int QUIET_PHASE = 21;
    localparam int HOLD_AT_WORD = 700;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam logic [2:0] UNMAPPED_REG = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // pixel_row, pixel_col, pixel_in (from the lowest bit up)
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // pixel_out
    logic [7:0]         m_tdata;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatches;
    int                 words_due;
    bit                 quiet = 1'b0;

    // Copy of the label setup, used only to aim pixels at the glyphs.
    logic [COORD_BITS-1:0] aim_row = '0;
    logic [COORD_BITS-1:0] aim_col = '0;
    int                    aim_h = 48;
    int                    aim_w = 32;
    int                    aim_hr = 2;
    int                    aim_hc = 1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    digit_label_overlay #(.COORD_BITS(COORD_BITS)) dut (.*);

    label_overlay_checker #(.COORD_BITS(COORD_BITS), .TDATA_W(TDATA_W)) overlay_check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .mismatches(mismatches), .words_due(words_due)
    );

    task automatic send_pixel(input logic [COORD_BITS-1:0] row, input logic [COORD_BITS-1:0] col,
                              input logic [7:0] grey);
        s_tdata <= TDATA_W'({grey, col, row});
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic source_gap(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_label(input logic [COORD_BITS-1:0] row, input logic [COORD_BITS-1:0] col,
                             input logic [6:0] value, input int h, input int w,
                             input int hr, input int hc);
        drain();
        reg_write(REG_CENTRE_ROW, 32'(row));
        reg_write(REG_CENTRE_COL, 32'(col));
        reg_write(REG_LABEL_VALUE, 32'(value));
        reg_write(REG_GLYPH_HEIGHT, 32'(h));
        reg_write(REG_GLYPH_WIDTH, 32'(w));
        reg_write(REG_STROKE_HALF_ROWS, 32'(hr));
        reg_write(REG_STROKE_HALF_COLS, 32'(hc));
        aim_row = row;
        aim_col = col;
        aim_h = h;
        aim_w = w;
        aim_hr = hr;
        aim_hc = hc;
    endtask

    // Most pixels land in the window around the label; a few are anywhere
    // in the picture or on image row or column 0.
    task automatic send_aimed(input bit gaps);
        int                    span_r;
        int                    span_c;
        int                    r;
        int                    c;
        int                    pick;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        span_r = aim_h / 2 + aim_hr + 3;
        span_c = aim_w + aim_hc + 3;
        r = int'(aim_row) + int'($urandom_range(0, 2 * span_r)) - span_r;
        c = int'(aim_col) + int'($urandom_range(0, 2 * span_c)) - span_c;
        row = r[COORD_BITS-1:0];
        col = c[COORD_BITS-1:0];
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            row = COORD_BITS'($urandom_range(0, 4095));
            col = COORD_BITS'($urandom_range(0, 4095));
        end
        else if (pick == 1)
        begin
            if ($urandom_range(0, 1) == 0)
                row = '0;
            else
                col = '0;
        end
        send_pixel(row, col, 8'($urandom_range(0, 255)));
        if (gaps && $urandom_range(0, 7) == 0)
            source_gap($urandom_range(1, 10));
    endtask

    initial
    begin : stimulus
        int                    phase;
        int                    i;
        int                    h;
        int                    w;
        int                    hr;
        int                    hc;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic [6:0]            value;
        bit                    gaps;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset setup: digit 0 centred on the image origin, partly clipped.
        send_pixel(12'd0, 12'd0, 8'd255);
        send_pixel(12'd0, 12'd5, 8'd77);
        send_pixel(12'd5, 12'd0, 8'd77);
        send_pixel(12'd2, 12'd15, 8'd128);
        send_pixel(12'd1, 12'd1, 8'd1);
        send_pixel(12'd4095, 12'd4095, 8'd0);
        send_pixel(12'd4095, 12'd4095, 8'd255);
        send_pixel(12'd2730, 12'd1365, 8'd170);
        send_pixel(12'd1365, 12'd2730, 8'd85);

        // Two digits around (100, 200), then a write to an unmapped address.
        set_label(12'd100, 12'd200, 7'd88, 48, 32, 2, 1);
        reg_write(UNMAPPED_REG, '1);
        send_pixel(12'd77, 12'd180, 8'd200);
        send_pixel(12'd100, 12'd170, 8'd200);
        send_pixel(12'd123, 12'd199, 8'd200);
        send_pixel(12'd100, 12'd200, 8'd200);
        send_pixel(12'd101, 12'd201, 8'd200);
        send_pixel(12'd76, 12'd180, 8'd200);
        send_pixel(12'd124, 12'd180, 8'd200);

        // A value too large to draw.
        set_label(12'd100, 12'd200, 7'd100, 48, 32, 2, 1);
        send_pixel(12'd100, 12'd180, 8'd99);
        send_pixel(12'd77, 12'd210, 8'd99);

        // One digit with stroke half thicknesses of zero.
        set_label(12'd100, 12'd200, 7'd7, 48, 32, 0, 0);
        send_pixel(12'd78, 12'd190, 8'd33);
        send_pixel(12'd100, 12'd215, 8'd33);

        for (phase = 0; phase < PHASES; phase++)
        begin
            row = COORD_BITS'($urandom_range(0, 4095));
            col = COORD_BITS'($urandom_range(0, 4095));
            h = $urandom_range(2, 64);
            w = $urandom_range(2, 48);
            hr = $urandom_range(0, 6);
            hc = $urandom_range(0, 6);
            if (phase < 10)
                value = 7'(phase * 11);
            else if (phase < 19)
                value = 7'(phase - 9);
            else
                value = 7'($urandom_range(0, 127));
            case (phase)
                18:
                begin
                    row = '0;
                    col = '0;
                end
                19:
                begin
                    row = '1;
                    col = '1;
                end
                20:
                begin
                    value = 7'd99;
                    h = 512;
                    w = 512;
                    hr = 64;
                    hc = 64;
                    row = 12'd2048;
                    col = 12'd2048;
                end
                21:
                begin
                    value = 7'd10;
                    h = 2;
                    w = 2;
                    hr = 0;
                    hc = 0;
                end
                22:
                begin
                    value = 7'($urandom_range(0, 99));
                    h = $urandom_range(0, 1);
                    w = $urandom_range(0, 1);
                end
                23:
                begin
                    value = 7'($urandom_range(100, 127));
                end
                default:
                begin
                end
            endcase
            if (phase == QUIET_PHASE)
                quiet = 1'b1;
            set_label(row, col, value, h, w, hr, hc);
            gaps = !quiet && $urandom_range(0, 3) != 0;
            for (i = 0; i < PHASE_WORDS; i++)
                send_aimed(gaps);
        end

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("[digit_label_overlay] OK");
        else
            $display("[digit_label_overlay] ERROR");
        $finish;
    end

    initial
    begin : sink
        int words;
        int burst;
        words = 0;
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                burst = $urandom_range(1, 10);
            end
            else
            begin
                m_tready <= 1'b1;
                burst = $urandom_range(1, 20);
            end
            repeat (burst)
            begin
                @(posedge clk);
                if (m_tvalid && m_tready)
                begin
                    words++;
                    // Long hold-off while the source keeps offering words, so the
                    // block fills up and has to drop s_tready.
                    if (words == HOLD_AT_WORD)
                    begin
                        m_tready <= 1'b0;
                        repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("[digit_label_overlay] ERROR");
        $finish;
    end

endmodule
